[rtl/abf_pkg.sv]
// Package for the auto brightness fader: payload structs, register map,
// register reset values and default timing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package abf_pkg;

  localparam int unsigned TimeW  = 48;
  localparam int unsigned LuxW   = 20;
  localparam int unsigned LevelW = 8;
  localparam int unsigned WeightW = 16;
  localparam int unsigned RatioW = 16;

  localparam int unsigned DefSamplePeriodUs = 500000;
  localparam int unsigned DefFadePeriodUs   = 50000;
  localparam int unsigned DefLuxFracBits    = 4;

  localparam int unsigned PaddrW = 5;
  localparam int unsigned PdataW = 32;

  // Register indexes (paddr[4:2]).
  localparam logic [2:0] RegEmaWeight  = 3'd0;
  localparam logic [2:0] RegDarkLux    = 3'd1;
  localparam logic [2:0] RegBrightLux  = 3'd2;
  localparam logic [2:0] RegDarkLevel  = 3'd3;
  localparam logic [2:0] RegBrightLevel = 3'd4;
  localparam logic [2:0] RegMaxLevel   = 3'd5;

  localparam logic [WeightW-1:0] RstEmaWeight   = 16'd13107;
  localparam logic [LuxW-1:0]    RstDarkLux     = 20'd160;
  localparam logic [LuxW-1:0]    RstBrightLux   = 20'd3200;
  localparam logic [LevelW-1:0]  RstDarkLevel   = 8'd20;
  localparam logic [LevelW-1:0]  RstBrightLevel = 8'd180;
  localparam logic [LevelW-1:0]  RstMaxLevel    = 8'd255;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic [LuxW-1:0]  lux_sample;
  } abf_in_t;

  typedef struct packed {
    logic              level_write;
    logic [LevelW-1:0] level_value;
    logic [LevelW-1:0] goal_level;
    logic [LuxW-1:0]   smoothed_lux;
    logic              level_known;
  } abf_out_t;

endpackage

`default_nettype wire

[rtl/auto_brightness_fader.sv]
// Auto brightness fader top level: APB register file, sequencer, serial units.
// Depends on abf_pkg, abf_mul_serial and abf_div_serial.
`timescale 1ns / 1ps
`default_nettype none

// One input transfer is taken at a time and produces exactly one result
// transfer. An item that finds no sample due passes through evaluate, fade and
// output, and a first sample that lands in the dark segment adds map and
// apply. Updating the running average adds a bit-serial multiply, the ratio
// adds the restoring divider, and the blend adds its setup and multiply. A
// ratio at twice the span or more skips the divider.
// The next item is accepted while the previous result still waits at the
// output register; a result that finds that register still full holds the
// sequencer until it drains. Registers lie at byte addresses 4*i; pready is
// always high.
module auto_brightness_fader #(
  parameter int unsigned SAMPLE_PERIOD_US = abf_pkg::DefSamplePeriodUs,
  parameter int unsigned FADE_PERIOD_US   = abf_pkg::DefFadePeriodUs,
  parameter int unsigned LUX_FRAC_BITS    = abf_pkg::DefLuxFracBits
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  abf_pkg::abf_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output abf_pkg::abf_out_t          out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [abf_pkg::PaddrW-1:0] paddr,
  input  logic [abf_pkg::PdataW-1:0] pwdata,
  output logic [abf_pkg::PdataW-1:0] prdata,
  output logic                       pready
);
  import abf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_EMA, S_MAP, S_DIV, S_SCALE, S_BLEND, S_APPLY, S_FADE, S_OUT
  } state_e;

  localparam logic [RatioW:0] RatioOne = (RatioW + 1)'(1) << RatioW;
  localparam logic [LuxW-1:0] OneLux   = LuxW'(1) << LUX_FRAC_BITS;

  // Configuration registers.
  logic [WeightW-1:0] ema_weight_q;
  logic [LuxW-1:0]    dark_lux_q, bright_lux_q;
  logic [LevelW-1:0]  dark_level_q, bright_level_q, max_level_q;

  // Block state.
  state_e            state_q;
  logic [LuxW-1:0]   avg_q;
  logic              seeded_q;
  logic [LevelW-1:0] present_q;
  logic              present_valid_q;
  logic [LevelW-1:0] target_q;
  logic [TimeW-1:0]  next_sample_q;
  logic [TimeW-1:0]  next_fade_q;

  // Per-item working registers.
  logic [TimeW-1:0]  now_q;
  logic [LuxW-1:0]   lux_q;
  logic              wr_q;
  logic              ema_up_q;
  logic [LevelW-1:0] base_q, top_q;
  logic [RatioW:0]   t_q;

  abf_out_t          out_q;
  logic              out_valid_q;

  logic [2:0]        reg_idx;
  logic              cfg_write;

  logic              lux_ge;
  logic [LuxW-1:0]   lux_delta;
  logic              lvl_up;
  logic [LevelW-1:0] lvl_delta;
  logic [LevelW-1:0] blend_off;
  logic              in_mid;
  logic [LuxW-1:0]   seg_diff;
  logic [LuxW-1:0]   seg_span;
  logic              ratio_over;

  logic              mul_start;
  logic [LuxW-1:0]   mul_a;
  logic [WeightW-1:0] mul_b;
  logic              mul_done;
  logic [LuxW-1:0]   mul_res;
  logic              div_start;
  logic              div_done;
  logic [RatioW:0]   div_quot;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PaddrW-1:2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ema_weight_q   <= RstEmaWeight;
      dark_lux_q     <= RstDarkLux;
      bright_lux_q   <= RstBrightLux;
      dark_level_q   <= RstDarkLevel;
      bright_level_q <= RstBrightLevel;
      max_level_q    <= RstMaxLevel;
    end else if (cfg_write) begin
      unique case (reg_idx)
        RegEmaWeight:   ema_weight_q   <= pwdata[WeightW-1:0];
        RegDarkLux:     dark_lux_q     <= pwdata[LuxW-1:0];
        RegBrightLux:   bright_lux_q   <= pwdata[LuxW-1:0];
        RegDarkLevel:   dark_level_q   <= pwdata[LevelW-1:0];
        RegBrightLevel: bright_level_q <= pwdata[LevelW-1:0];
        RegMaxLevel:    max_level_q    <= pwdata[LevelW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegEmaWeight:   prdata = PdataW'(ema_weight_q);
      RegDarkLux:     prdata = PdataW'(dark_lux_q);
      RegBrightLux:   prdata = PdataW'(bright_lux_q);
      RegDarkLevel:   prdata = PdataW'(dark_level_q);
      RegBrightLevel: prdata = PdataW'(bright_level_q);
      RegMaxLevel:    prdata = PdataW'(max_level_q);
      default:        prdata = '0;
    endcase
  end

  // Datapath helpers.
  assign lux_ge    = lux_q >= avg_q;
  assign lux_delta = lux_ge ? (lux_q - avg_q) : (avg_q - lux_q);
  assign lvl_up    = top_q >= base_q;
  assign lvl_delta = lvl_up ? (top_q - base_q) : (base_q - top_q);
  // A full ratio reaches the top level exactly.
  assign blend_off = t_q[RatioW] ? lvl_delta : mul_res[LevelW-1:0];

  assign in_mid   = avg_q < bright_lux_q;
  assign seg_diff = in_mid ? (avg_q - dark_lux_q) : (avg_q - bright_lux_q);
  always_comb begin
    if (in_mid) begin
      seg_span = bright_lux_q - dark_lux_q;
    end else if (bright_lux_q != '0) begin
      seg_span = bright_lux_q;
    end else begin
      seg_span = OneLux;
    end
  end
  // At twice the span or more the ratio is clamped without dividing.
  assign ratio_over = {1'b0, seg_diff} >= {seg_span, 1'b0};

  always_comb begin
    mul_start = 1'b0;
    mul_a     = lux_delta;
    mul_b     = ema_weight_q;
    div_start = 1'b0;
    if (state_q == S_EVAL) begin
      mul_start = (now_q >= next_sample_q) && seeded_q;
    end else if (state_q == S_SCALE) begin
      mul_start = 1'b1;
      mul_a     = LuxW'(lvl_delta);
      mul_b     = t_q[RatioW-1:0];
    end else if (state_q == S_MAP) begin
      div_start = (avg_q >= dark_lux_q) && !ratio_over;
    end
  end

  abf_mul_serial u_mul (
    .clk_i,
    .rst_ni,
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .done_o   (mul_done),
    .result_o (mul_res)
  );

  abf_div_serial u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .diff_i  (seg_diff),
    .span_i  (seg_span),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      avg_q           <= '0;
      seeded_q        <= 1'b0;
      present_q       <= '0;
      present_valid_q <= 1'b0;
      target_q        <= '0;
      next_sample_q   <= '0;
      next_fade_q     <= '0;
      wr_q            <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            wr_q    <= 1'b0;
            state_q <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (now_q >= next_sample_q) begin
            next_sample_q <= now_q + TimeW'(SAMPLE_PERIOD_US);
            if (!seeded_q) begin
              avg_q    <= lux_q;
              seeded_q <= 1'b1;
              state_q  <= S_MAP;
            end else begin
              state_q <= S_EMA;
            end
          end else begin
            state_q <= S_FADE;
          end
        end
        S_EMA: begin
          if (mul_done) begin
            avg_q   <= ema_up_q ? (avg_q + mul_res) : (avg_q - mul_res);
            state_q <= S_MAP;
          end
        end
        S_MAP: begin
          if (avg_q < dark_lux_q) begin
            target_q <= dark_level_q;
            state_q  <= S_APPLY;
          end else begin
            base_q <= in_mid ? dark_level_q : bright_level_q;
            top_q  <= in_mid ? bright_level_q : max_level_q;
            if (ratio_over) begin
              t_q     <= RatioOne;
              state_q <= S_SCALE;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            t_q     <= (div_quot > RatioOne) ? RatioOne : div_quot;
            state_q <= S_SCALE;
          end
        end
        S_SCALE: begin
          state_q <= S_BLEND;
        end
        S_BLEND: begin
          if (mul_done) begin
            target_q <= lvl_up ? (base_q + blend_off) : (base_q - blend_off);
            state_q  <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (!present_valid_q) begin
            present_q       <= target_q;
            present_valid_q <= 1'b1;
            wr_q            <= 1'b1;
          end
          state_q <= S_FADE;
        end
        S_FADE: begin
          if (present_valid_q && (present_q != target_q) && (now_q >= next_fade_q)) begin
            next_fade_q <= now_q + TimeW'(FADE_PERIOD_US);
            present_q   <= (present_q < target_q) ? (present_q + 1'b1) : (present_q - 1'b1);
            wr_q        <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      now_q <= in_data_i.now_us;
      lux_q <= in_data_i.lux_sample;
    end
    if (state_q == S_EVAL) begin
      ema_up_q <= lux_ge;
    end
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_q.level_write  <= wr_q;
      out_q.level_value  <= present_q;
      out_q.goal_level   <= target_q;
      out_q.smoothed_lux <= avg_q;
      out_q.level_known  <= present_valid_q;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/abf_mul_serial.sv]
// Bit-serial shift-add multiplier returning floor(a * b / 2^16).
// Uses abf_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module abf_mul_serial (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [abf_pkg::LuxW-1:0]     a_i,
  input  logic [abf_pkg::WeightW-1:0]  b_i,
  output logic                         done_o,
  output logic [abf_pkg::LuxW-1:0]     result_o
);
  import abf_pkg::*;

  localparam int unsigned CntW = $clog2(WeightW + 1);

  logic [LuxW-1:0]    a_q;
  logic [WeightW-1:0] b_q;
  logic [LuxW-1:0]    acc_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [LuxW:0]      sum;

  // One multiplier bit per cycle, LSB first; the accumulator keeps only the
  // high part, so the bits shifted out are exactly the truncated fraction.
  assign sum = {1'b0, acc_q} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(WeightW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sum[LuxW:1];
      b_q   <= {1'b0, b_q[WeightW-1:1]};
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

`default_nettype wire

[rtl/abf_div_serial.sv]
// Restoring divider producing floor(diff * 2^16 / span), one quotient bit per cycle.
// Requires diff < 2 * span and span > 0. Uses abf_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module abf_div_serial (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [abf_pkg::LuxW-1:0]    diff_i,
  input  logic [abf_pkg::LuxW-1:0]    span_i,
  output logic                        done_o,
  output logic [abf_pkg::RatioW:0]    quot_o
);
  import abf_pkg::*;

  localparam int unsigned Steps = RatioW + 1;
  localparam int unsigned CntW  = $clog2(Steps + 1);

  logic [LuxW:0]    rem_q;
  logic [LuxW-1:0]  span_q;
  logic [RatioW:0]  quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [LuxW:0]    trial;
  logic             fits;

  // The first step tests the integer bit of the ratio without a shift; every
  // later step brings down a zero bit of the scaled dividend.
  assign trial = (cnt_q == '0) ? rem_q : {rem_q[LuxW-1:0], 1'b0};
  assign fits  = trial >= {1'b0, span_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {1'b0, diff_i};
      span_q <= span_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? (trial - {1'b0, span_q}) : trial;
      quot_q <= {quot_q[RatioW-1:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire
